// ===== rtl/record_sort_by_id_or_date_core_defines.svh =====
// Assertion macros shared by the record sorter checker
`ifndef RECORD_SORT_BY_ID_OR_DATE_CORE_DEFINES_SVH
`define RECORD_SORT_BY_ID_OR_DATE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define RSBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger
`define RSBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rsbd_pkg.sv =====
// Shared types and constants of the record sorter
`timescale 1ns / 1ps
`default_nettype none
package rsbd_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // One stored record, 63 bits
   typedef struct packed {
      logic [15:0] id;
      logic [23:0] price;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } rec_type;

   // Key modes
   localparam logic MODE_ID   = 1'b0;
   localparam logic MODE_DATE = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/record_sort_by_id_or_date_core.sv =====
// Top level of the record sorter: load, bubble sort and emit sequencer
//
// Usage: records arrive on the req_ channel (valid/ready). Each transfer
// stores one record in a 16-entry store, one cycle per record; a record
// that finds the store full is dropped and rsp_overflowed is set on every
// result of that set. A transfer with req_last_in high starts the sort.
// The sort is a stable bubble sort run by one compare unit and one store
// read port; each pass stops one entry short of the pass before it.
// Results then leave on the rsp_ channel, each record read from the store
// and then loaded into the output register, the last one marked by
// rsp_out_last. req_ready stays low from the last transfer until the final
// record is loaded into the output register. A stalled receiver holds the
// output register and the sequencer waits. csr_write_data, written with
// csr_write_enable, selects id order (0) or date-then-id order (1); write it
// only while idle. Reset empties the store, clears the drop flag, sets id
// order and leaves the output channel empty; it needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module record_sort_by_id_or_date_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_rec_id,
   input  wire logic [23:0] req_price_cents,
   input  wire logic [4:0]  req_day_in,
   input  wire logic [3:0]  req_month_in,
   input  wire logic [13:0] req_year_in,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_out_id,
   output logic [23:0]      rsp_out_price,
   output logic [4:0]       rsp_out_day,
   output logic [3:0]       rsp_out_month,
   output logic [13:0]      rsp_out_year,
   output logic             rsp_out_last,
   output logic             rsp_overflowed
);
   import rsbd_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PSTART = 7'b0000010,
      S_PHOLD  = 7'b0000100,
      S_STEP   = 7'b0001000,
      S_PEND   = 7'b0010000,
      S_ERD    = 7'b0100000,
      S_ELOAD  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff, drop_in;
   logic              mode_ff;
   logic [IDX_W-1:0]  pass_end_ff, pass_end_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  e_ff, e_in;
   rec_type           hold_ff, hold_in;

   logic              out_valid_ff, out_valid_in;
   rec_type           out_rec_ff, out_rec_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   rec_type           wr_data;
   logic [IDX_W-1:0]  rd_addr;
   rec_type           rd_data;
   logic              after;

   logic              accept;
   logic              store_ok;
   logic [CNT_W-1:0]  count_new;
   logic              slot_free;
   rec_type           req_rec;

   rsbd_store u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   rsbd_cmp u_cmp (
      .sort_mode  (mode_ff),
      .a          (hold_ff),
      .b          (rd_data),
      .goes_after (after)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign store_ok  = (count_ff < CNT_W'(CAPACITY));
   assign count_new = count_ff + CNT_W'(store_ok);
   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      req_rec.id    = req_rec_id;
      req_rec.price = req_price_cents;
      req_rec.day   = req_day_in;
      req_rec.month = req_month_in;
      req_rec.year  = req_year_in;
   end

   // Sequence loading, sorting passes and emitting
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      pass_end_in  = pass_end_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      hold_in      = hold_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = hold_ff;
      rd_addr      = '0;
      out_rec_in   = out_rec_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wr_addr = count_ff[IDX_W-1:0];
               wr_data = req_rec;
               if (store_ok) begin
                  wr_en    = 1'b1;
                  count_in = count_new;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_in) begin
                  e_in = '0;
                  if (count_new == '0) begin
                     drop_in = 1'b0;
                  end else if (count_new == CNT_W'(1)) begin
                     state_in = S_ERD;
                  end else begin
                     pass_end_in = IDX_W'(count_new - CNT_W'(1));
                     state_in    = S_PSTART;
                  end
               end
            end
         end
         S_PSTART: begin
            rd_addr  = '0;
            state_in = S_PHOLD;
         end
         S_PHOLD: begin
            hold_in  = rd_data;
            k_in     = '0;
            rd_addr  = IDX_W'(1);
            state_in = S_STEP;
         end
         S_STEP: begin
            // Write the lower record back, carry the larger one onward
            wr_en   = 1'b1;
            wr_addr = k_ff;
            if (after) begin
               wr_data = rd_data;
            end else begin
               wr_data = hold_ff;
               hold_in = rd_data;
            end
            if (k_ff + IDX_W'(1) == pass_end_ff) begin
               state_in = S_PEND;
            end else begin
               k_in    = k_ff + IDX_W'(1);
               rd_addr = k_ff + IDX_W'(2);
            end
         end
         S_PEND: begin
            wr_en   = 1'b1;
            wr_addr = pass_end_ff;
            wr_data = hold_ff;
            if (pass_end_ff == IDX_W'(1)) begin
               e_in     = '0;
               state_in = S_ERD;
            end else begin
               pass_end_in = pass_end_ff - IDX_W'(1);
               state_in    = S_PSTART;
            end
         end
         S_ERD: begin
            rd_addr  = e_ff;
            state_in = S_ELOAD;
         end
         S_ELOAD: begin
            rd_addr = e_ff;
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_rec_in   = rd_data;
               out_ovf_in   = drop_ff;
               out_last_in  = (CNT_W'(e_ff) + CNT_W'(1) == count_ff);
               if (CNT_W'(e_ff) + CNT_W'(1) == count_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  e_in     = e_ff + IDX_W'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         mode_ff      <= MODE_ID;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pass_end_ff <= pass_end_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      hold_ff     <= hold_in;
      out_rec_ff  <= out_rec_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_id     = out_rec_ff.id;
   assign rsp_out_price  = out_rec_ff.price;
   assign rsp_out_day    = out_rec_ff.day;
   assign rsp_out_month  = out_rec_ff.month;
   assign rsp_out_year   = out_rec_ff.year;
   assign rsp_out_last   = out_last_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/rsbd_store.sv =====
// Record store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module rsbd_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [rsbd_pkg::IDX_W-1:0] wr_addr,
   input  wire rsbd_pkg::rec_type         wr_data,
   input  wire logic [rsbd_pkg::IDX_W-1:0] rd_addr,
   output rsbd_pkg::rec_type              rd_data_ff
);
   import rsbd_pkg::*;

   rec_type mem [CAPACITY];

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/rsbd_cmp.sv =====
// Key compare unit: flags when record a must move after record b
`timescale 1ns / 1ps
`default_nettype none
module rsbd_cmp (
   input  wire logic              sort_mode,
   input  wire rsbd_pkg::rec_type a,
   input  wire rsbd_pkg::rec_type b,
   output logic                   goes_after
);
   import rsbd_pkg::*;

   logic [38:0] key_a;
   logic [38:0] key_b;

   // Build date-then-id keys; id mode compares the id alone
   always_comb begin
      key_a = {a.year, a.month, a.day, a.id};
      key_b = {b.year, b.month, b.day, b.id};
      if (sort_mode == MODE_DATE) begin
         goes_after = key_a > key_b;
      end else begin
         goes_after = a.id > b.id;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rsbd_checker.sv =====
// Port-level checker of the record sorter and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "record_sort_by_id_or_date_core_defines.svh"
module rsbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last_in,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_out_id,
   input wire logic [23:0] rsp_out_price,
   input wire logic [4:0]  rsp_out_day,
   input wire logic [3:0]  rsp_out_month,
   input wire logic [13:0] rsp_out_year,
   input wire logic        rsp_out_last,
   input wire logic        rsp_overflowed
);

   logic [64:0] rsp_word;

   // Gather every result field for the hold check
   assign rsp_word = {rsp_out_id, rsp_out_price, rsp_out_day, rsp_out_month,
                      rsp_out_year, rsp_out_last, rsp_overflowed};

   // Leave reset idle with an empty output
   `RSBD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")

   // Hold a stalled result
   `RSBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled result changed")

   // Take the next record right after a plain load
   `RSBD_ASSERT_NEXT(a_load_ready, clock, reset, req_valid && req_ready && !req_last_in, req_ready, "not ready after a plain load")

   // Refuse input while a set is still being emitted
   `RSBD_ASSERT_NOW(a_busy_emit, clock, reset, rsp_valid && !rsp_out_last, !req_ready, "ready during emit")

endmodule

bind record_sort_by_id_or_date_core rsbd_checker u_rsbd_checker (.*);
`default_nettype wire

// ===== test/tb_record_sort_by_id_or_date_core.sv =====
// Testbench for the record sorter: random sets, sort-order prediction and result checks
`timescale 1ns / 1ps

// One sorted record as it should leave the result channel
typedef struct packed {
   rsbd_pkg::rec_type rec;
   logic              last;
   logic              ovf;
} sorted_entry_type;

// Tracks the records of the open set and the sorted records still due
class sorted_record_tracker;
   rsbd_pkg::rec_type held[$];
   sorted_entry_type  due[$];
   bit                dropped;
   bit                mode;
   int                errors;

   function new();
      dropped = 1'b0;
      mode    = rsbd_pkg::MODE_ID;
      errors  = 0;
   endfunction

   // True when record a must land after record b
   function bit goes_later(rsbd_pkg::rec_type a, rsbd_pkg::rec_type b);
      if (mode == rsbd_pkg::MODE_ID) begin
         return a.id > b.id;
      end
      return {a.year, a.month, a.day, a.id} > {b.year, b.month, b.day, b.id};
   endfunction

   // Stable exchange sort of the open set, then queue its records in order
   function void order_set();
      rsbd_pkg::rec_type a[$];
      rsbd_pkg::rec_type t;
      sorted_entry_type  e;
      int                n;
      a = held;
      n = a.size();
      for (int pass = 0; pass + 1 < n; pass++) begin
         for (int k = 0; k + 1 < n - pass; k++) begin
            if (goes_later(a[k], a[k + 1])) begin
               t        = a[k];
               a[k]     = a[k + 1];
               a[k + 1] = t;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         e.rec  = a[k];
         e.last = (k + 1 == n);
         e.ovf  = dropped;
         due.push_back(e);
      end
   endfunction

   // Store or drop an accepted record; the last one closes the set
   function void note_record(rsbd_pkg::rec_type r, bit last);
      if (held.size() < rsbd_pkg::CAPACITY) begin
         held.push_back(r);
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         order_set();
         held.delete();
         dropped = 1'b0;
      end
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Compare one result transfer with the oldest record due
   function void check_result(rsbd_pkg::rec_type got, logic last, logic ovf);
      sorted_entry_type e;
      if (due.size() == 0) begin
         $error("result with nothing due: id %0d", got.id);
         errors++;
         return;
      end
      e = due.pop_front();
      compare_field("out_id", 32'(e.rec.id), 32'(got.id));
      compare_field("out_price", 32'(e.rec.price), 32'(got.price));
      compare_field("out_day", 32'(e.rec.day), 32'(got.day));
      compare_field("out_month", 32'(e.rec.month), 32'(got.month));
      compare_field("out_year", 32'(e.rec.year), 32'(got.year));
      compare_field("out_last", 32'(e.last), 32'(last));
      compare_field("overflowed", 32'(e.ovf), 32'(ovf));
   endfunction

   function int pending();
      return due.size();
   endfunction
endclass

module tb_record_sort_by_id_or_date_core;
   import rsbd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_AT        = 40;
   localparam int HOLD_CYCLES    = 500;
   localparam int RANDOM_ITEMS   = 400;
   localparam int PHASE_ITEMS    = 80;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data   = 1'b0;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [15:0] req_rec_id       = '0;
   logic [23:0] req_price_cents  = '0;
   logic [4:0]  req_day_in       = '0;
   logic [3:0]  req_month_in     = '0;
   logic [13:0] req_year_in      = '0;
   logic        req_last_in      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [15:0] rsp_out_id;
   logic [23:0] rsp_out_price;
   logic [4:0]  rsp_out_day;
   logic [3:0]  rsp_out_month;
   logic [13:0] rsp_out_year;
   logic        rsp_out_last;
   logic        rsp_overflowed;

   sorted_record_tracker rec_tracker;
   bit                   send_burst = 1'b0;

   record_sort_by_id_or_date_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rec_id       (req_rec_id),
      .req_price_cents  (req_price_cents),
      .req_day_in       (req_day_in),
      .req_month_in     (req_month_in),
      .req_year_in      (req_year_in),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_price    (rsp_out_price),
      .rsp_out_day      (rsp_out_day),
      .rsp_out_month    (rsp_out_month),
      .rsp_out_year     (rsp_out_year),
      .rsp_out_last     (rsp_out_last),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Offer one record after a random gap and hold it until the transfer
   task automatic send_record(rec_type r, bit last);
      int gap;
      gap = send_burst ? 0 : int'($urandom_range(9, 0));
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rec_id      <= r.id;
      req_price_cents <= r.price;
      req_day_in      <= r.day;
      req_month_in    <= r.month;
      req_year_in     <= r.year;
      req_last_in     <= last;
      do @(posedge clock); while (!req_ready);
      rec_tracker.note_record(r, last);
   endtask

   // Drop valid, wait for every due result, then let the block settle
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rec_tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the key mode; only called while the block is idle
   task automatic write_sort_mode(bit m);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      rec_tracker.mode = m;
   endtask

   // Profile 0: any bits; 1: in-range day, month and year; 2: few distinct keys to force ties
   function automatic rec_type make_record(int profile);
      rec_type r;
      r.id    = 16'($urandom);
      r.price = 24'($urandom);
      case (profile)
         0: begin
            r.day   = 5'($urandom);
            r.month = 4'($urandom);
            r.year  = 14'($urandom);
         end
         1: begin
            r.day   = 5'($urandom_range(31, 1));
            r.month = 4'($urandom_range(12, 1));
            r.year  = 14'($urandom_range(9999, 0));
         end
         default: begin
            r.id    = ($urandom_range(7, 0) == 0) ? 16'hFFFF : 16'($urandom_range(3, 0));
            r.day   = 5'($urandom_range(2, 1));
            r.month = 4'($urandom_range(2, 1));
            r.year  = ($urandom_range(1, 0) == 0) ? 14'd2000 : 14'd2001;
         end
      endcase
      return r;
   endfunction

   // Send one set of n records, the last one marked
   task automatic send_set(int n, int profile);
      for (int i = 0; i < n; i++) begin
         send_record(make_record(profile), i == n - 1);
      end
   endtask

   // Receiver: random stalls, bursts, and one long hold-off
   initial begin
      int          gap;
      int unsigned taken;
      bit          rsp_burst;
      bit          held_off;
      rec_type     got;
      taken     = 0;
      rsp_burst = 1'b0;
      held_off  = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(11, 0) == 0) begin
            rsp_burst = ~rsp_burst;
         end
         gap = rsp_burst ? 0 : int'($urandom_range(9, 0));
         if (!held_off && taken == HOLD_AT) begin
            gap      = HOLD_CYCLES;
            held_off = 1'b1;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.id    = rsp_out_id;
         got.price = rsp_out_price;
         got.day   = rsp_out_day;
         got.month = rsp_out_month;
         got.year  = rsp_out_year;
         rec_tracker.check_result(got, rsp_out_last, rsp_overflowed);
         taken++;
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      rec_type r;
      int      sent;
      int      n;
      int      pick;
      int      profile;
      rec_tracker = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_sort_mode(MODE_ID);

      // Single record with every field at its all-ones extreme
      r = '1;
      send_record(r, 1'b1);

      // Full store: duplicate ids, an all-zero record, and a dropped last item
      for (int i = 0; i < 17; i++) begin
         if (i == 3) begin
            r = '0;
         end else begin
            r.id    = 16'hFFFF - 16'(i % 5);
            r.price = 24'hFFFFFF - 24'(i);
            r.day   = 5'(2 * i + 1);
            r.month = 4'(i);
            r.year  = 14'(i * 1000);
         end
         send_record(r, i == 16);
      end
      drain_block();

      // Date order: ties on date, ties on id, year over month, out-of-range fields
      write_sort_mode(MODE_DATE);
      send_record('{id: 16'd7, price: 24'd1, day: 5'd10, month: 4'd5, year: 14'd2024}, 1'b0);
      send_record('{id: 16'd3, price: 24'd2, day: 5'd10, month: 4'd5, year: 14'd2024}, 1'b0);
      send_record('{id: 16'd9, price: 24'd3, day: 5'd31, month: 4'd12, year: 14'd2023}, 1'b0);
      send_record('{id: 16'd1, price: 24'd4, day: 5'd0, month: 4'd13, year: 14'd2024}, 1'b0);
      send_record('{id: 16'd3, price: 24'd5, day: 5'd10, month: 4'd5, year: 14'd2024}, 1'b0);
      send_record('{id: 16'hFFFF, price: 24'd6, day: 5'd1, month: 4'd1, year: 14'd0}, 1'b1);
      drain_block();

      // Random phases, alternating key mode at each idle point
      sent = 0;
      for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
         write_sort_mode(phase[0] ? MODE_ID : MODE_DATE);
         for (int p = 0; p < PHASE_ITEMS && sent < RANDOM_ITEMS; p += n) begin
            pick = int'($urandom_range(99, 0));
            if (pick < 10) begin
               n = 1;
            end else if (pick < 20) begin
               n = CAPACITY;
            end else if (pick < 32) begin
               n = int'($urandom_range(CAPACITY + 8, CAPACITY + 1));
            end else begin
               n = int'($urandom_range(CAPACITY - 1, 2));
            end
            profile    = int'($urandom_range(2, 0));
            send_burst = ($urandom_range(3, 0) == 0);
            send_set(n, profile);
            sent += n;
         end
         drain_block();
      end

      if (rec_tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== record_sort_by_id_or_date_core.f =====
+incdir+rtl
rtl/rsbd_pkg.sv
rtl/rsbd_store.sv
rtl/rsbd_cmp.sv
rtl/record_sort_by_id_or_date_core.sv
rtl/rsbd_checker.sv
test/tb_record_sort_by_id_or_date_core.sv
